// ===== sv/assert_macros.svh =====
// Assertion macros shared by the replay window table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define GRWT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GRWT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/grwt_pkg.sv =====
// Types, codes and constants for the group replay window table.
`timescale 1ns / 1ps

package grwt_pkg;

   localparam int SENDERS_DEF = 8;
   localparam int WINDOW_SIZE = 64;
   localparam int DIST_W      = $clog2(WINDOW_SIZE);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_EPOCH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_EPOCH    = 1'b1;

   // request operations
   localparam logic OP_CHECK  = 1'b0;
   localparam logic OP_COMMIT = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REPLAY = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic        op;
      logic        link_scope;
      logic [15:0] sender_id;
      logic [31:0] epoch;
      logic [31:0] boot;
      logic [63:0] counter;
   } grwt_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       known_sender;
   } grwt_rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] boot;
   } sndr_entry_type;

   typedef struct packed {
      logic [63:0] top;
      logic [63:0] bits;
   } win_entry_type;

   typedef struct packed {
      logic [63:0] diff;
      logic        borrow;
      logic        zero;
   } sub_res_type;

   // window store control group
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_slot_en;
      logic clr_bank_en;
      logic clr_bank;
   } win_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WRD,
      ST_WCMP,
      ST_WDST,
      ST_WFIN,
      ST_RESP
   } grwt_state_type;

endpackage

// ===== sv/group_replay_window_table_top.sv =====
// Group replay window table: per-sender 64-bit anti-replay windows, two scopes.
// Handles one request at a time: req_stall is high until the response is loaded, and each
// request goes through the sender table scan, a decide step and, when a window is read or
// updated, the window steps before rsp_valid. The scan reads one entry per cycle through
// the sender table's single read port.
// Reset: synchronous; clears control, valid bits, bank labels and epoch registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module group_replay_window_table_top #(
   parameter int SENDERS = grwt_pkg::SENDERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  grwt_pkg::grwt_req_type            req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output grwt_pkg::grwt_rsp_type            rsp_data,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [grwt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import grwt_pkg::*;

   localparam int SLOT_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;
   localparam int CNT_W   = $clog2(SENDERS + 1);
   localparam int ADDR_W  = $clog2(2 * SENDERS);
   localparam int WADDR_W = $clog2(4 * SENDERS);
   localparam logic [ADDR_W-1:0] SCOPE_BASE = ADDR_W'(SENDERS);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   grwt_state_type      state_ff, state_in;
   grwt_req_type        req_ff, req_in;

   // scan pipeline: issue counter runs one ahead of the compare
   logic [CNT_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]   cmp_slot_ff, cmp_slot_in;

   // scan results
   logic                known_ff, known_in;
   logic [SLOT_W-1:0]   known_slot_ff, known_slot_in;
   logic                free_ff, free_in;
   logic [SLOT_W-1:0]   free_slot_ff, free_slot_in;
   logic [31:0]         floor_ff, floor_in;

   // chosen window
   logic [ADDR_W-1:0]   slot_abs_ff, slot_abs_in;
   logic                bank_ff, bank_in;
   logic                gt_ff, gt_in;
   logic [63:0]         diff_ff, diff_in;
   logic [1:0]          status_ff, status_in;

   logic [31:0]         label_ff [2];
   logic [31:0]         label_in [2];
   logic [31:0]         cur_ep_ff, cur_ep_in;
   logic [31:0]         nxt_ep_ff, nxt_ep_in;

   logic                rsp_valid_ff, rsp_valid_in;
   grwt_rsp_type        rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------------
   // Shared units and stores
   // ---------------------------------------------------------------------
   logic [63:0]         sub_a, sub_b;
   sub_res_type         sub_res;

   logic                snd_rd_en;
   logic [ADDR_W-1:0]   snd_rd_addr;
   sndr_entry_type      snd_rd_data;
   logic                snd_wr_en;
   logic [ADDR_W-1:0]   snd_wr_addr;
   sndr_entry_type      snd_wr_data;

   win_ctrl_type        win_ctrl;
   logic [WADDR_W-1:0]  win_addr;
   win_entry_type       win_wr_data;
   win_entry_type       win_rd_data;

   grwt_sub u_sub (
      .a   (sub_a),
      .b   (sub_b),
      .res (sub_res)
   );

   grwt_sndr_store #(.SENDERS(SENDERS)) u_sndr (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (snd_rd_en),
      .rd_addr (snd_rd_addr),
      .rd_data (snd_rd_data),
      .wr_en   (snd_wr_en),
      .wr_addr (snd_wr_addr),
      .wr_data (snd_wr_data)
   );

   grwt_win_store #(.SENDERS(SENDERS)) u_win (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win_ctrl),
      .addr    (win_addr),
      .wr_data (win_wr_data),
      .rd_data (win_rd_data)
   );

   // ---------------------------------------------------------------------
   // Decode helpers
   // ---------------------------------------------------------------------
   logic                req_acc;
   logic                iss_more;
   logic                scan_last;
   logic                have_slot;
   logic [SLOT_W-1:0]   slot_sel;
   logic [ADDR_W-1:0]   sel_abs;
   logic                is_commit;
   logic                boot_gt, boot_lt, boot_eq;
   logic                match0, match1, match_any;
   logic                retire_bank;
   logic                new_entry;
   logic                win_gt;
   logic                dist_small;
   logic                rsp_load;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign iss_more  = (iss_cnt_ff < CNT_W'(SENDERS));
   assign scan_last = cmp_vld_ff && (cmp_slot_ff == SLOT_W'(SENDERS - 1));

   assign is_commit = (req_ff.op == OP_COMMIT);
   assign have_slot = known_ff || free_ff;
   assign slot_sel  = known_ff ? known_slot_ff : free_slot_ff;
   assign sel_abs   = ADDR_W'(slot_sel) + (req_ff.link_scope ? SCOPE_BASE : '0);

   // boot vs floor is only looked at in the decide step
   assign boot_lt   = sub_res.borrow;
   assign boot_gt   = !sub_res.borrow && !sub_res.zero;
   assign boot_eq   = sub_res.zero;

   // bank 0 wins when both labels match the epoch
   assign match0    = (label_ff[0] == req_ff.epoch);
   assign match1    = (label_ff[1] == req_ff.epoch);
   assign match_any = match0 || match1;
   // bank 0 retires unless its epoch is still accepted
   assign retire_bank = (label_ff[0] == cur_ep_ff) || (label_ff[0] == nxt_ep_ff);
   // a free slot or a newer boot starts afresh
   assign new_entry = !known_ff || boot_gt;

   assign win_gt     = !sub_res.borrow && !sub_res.zero;
   assign dist_small = (diff_ff[63:DIST_W] == '0);

   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!have_slot) begin
               state_in = ST_RESP;
            end else if (is_commit) begin
               state_in = ST_WRD;
            end else if (known_ff && boot_eq && match_any) begin
               state_in = ST_WRD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WRD: begin
            state_in = ST_WCMP;
         end
         ST_WCMP: begin
            if (!win_gt) begin
               state_in = ST_WDST;
            end else if (is_commit) begin
               state_in = ST_WFIN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WDST: begin
            state_in = ST_WFIN;
         end
         ST_WFIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs: store controls and shared unit operands
   // ---------------------------------------------------------------------
   always_comb begin
      sub_a       = '0;
      sub_b       = '0;
      snd_rd_en   = 1'b0;
      snd_rd_addr = ADDR_W'(iss_cnt_ff[SLOT_W-1:0])
                    + (req_ff.link_scope ? SCOPE_BASE : '0);
      snd_wr_en   = 1'b0;
      snd_wr_addr = sel_abs;
      snd_wr_data.id   = req_ff.sender_id;
      snd_wr_data.boot = new_entry ? req_ff.boot : floor_ff;
      win_ctrl    = '0;
      win_ctrl.clr_bank = retire_bank;
      win_addr    = {slot_abs_ff, bank_ff};
      win_wr_data = win_rd_data;

      case (state_ff)
         ST_SCAN: begin
            snd_rd_en = iss_more;
         end
         ST_DECIDE: begin
            sub_a = {32'd0, req_ff.boot};
            sub_b = {32'd0, floor_ff};
            if (is_commit && have_slot) begin
               snd_wr_en            = 1'b1;
               win_ctrl.clr_slot_en = new_entry;
               win_ctrl.clr_bank_en = !match_any;
               // slot clear addresses the selected slot
               win_addr             = {sel_abs, 1'b0};
            end
         end
         ST_WRD: begin
            win_ctrl.rd_en = 1'b1;
         end
         ST_WCMP: begin
            sub_a = req_ff.counter;
            sub_b = win_rd_data.top;
         end
         ST_WDST: begin
            sub_a = win_rd_data.top;
            sub_b = req_ff.counter;
         end
         ST_WFIN: begin
            win_ctrl.wr_en = is_commit;
            if (gt_ff) begin
               // slide forward, newest counter at bit 0
               win_wr_data.top  = req_ff.counter;
               win_wr_data.bits = (dist_small ? (win_rd_data.bits << diff_ff[DIST_W-1:0])
                                              : 64'd0) | 64'd1;
            end else if (dist_small) begin
               win_wr_data.bits = win_rd_data.bits | (64'd1 << diff_ff[DIST_W-1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      req_in        = req_ff;
      iss_cnt_in    = iss_cnt_ff;
      cmp_vld_in    = 1'b0;
      cmp_slot_in   = iss_cnt_ff[SLOT_W-1:0];
      known_in      = known_ff;
      known_slot_in = known_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      floor_in      = floor_ff;
      slot_abs_in   = slot_abs_ff;
      bank_in       = bank_ff;
      gt_in         = gt_ff;
      diff_in       = diff_ff;
      status_in     = status_ff;
      label_in      = label_ff;
      cur_ep_in     = cur_ep_ff;
      nxt_ep_in     = nxt_ep_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CURRENT_EPOCH: cur_ep_in = csr_wdata;
            CSR_NEXT_EPOCH:    nxt_ep_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               req_in     = req_data;
               iss_cnt_in = '0;
               known_in   = 1'b0;
               free_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            if (iss_more) begin
               iss_cnt_in = iss_cnt_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               // id zero never counts as a known sender
               if (!known_ff && req_ff.sender_id != 16'd0
                   && snd_rd_data.id == req_ff.sender_id) begin
                  known_in      = 1'b1;
                  known_slot_in = cmp_slot_ff;
                  floor_in      = snd_rd_data.boot;
               end
               if (!free_ff && snd_rd_data.id == 16'd0) begin
                  free_in      = 1'b1;
                  free_slot_in = cmp_slot_ff;
               end
            end
         end
         ST_DECIDE: begin
            slot_abs_in = sel_abs;
            bank_in     = match0 ? 1'b0 : (match1 ? 1'b1 : retire_bank);
            if (!have_slot) begin
               status_in = STATUS_FULL;
            end else if (!is_commit && known_ff && boot_lt) begin
               status_in = STATUS_REPLAY;
            end else begin
               status_in = STATUS_OK;
            end
            if (is_commit && have_slot && !match_any) begin
               label_in[retire_bank] = req_ff.epoch;
            end
         end
         ST_WCMP: begin
            gt_in   = win_gt;
            diff_in = sub_res.diff;
         end
         ST_WDST: begin
            diff_in = sub_res.diff;
         end
         ST_WFIN: begin
            // an old counter is a replay if outside the window or already seen
            if (!is_commit && !(dist_small && !win_rd_data.bits[diff_ff[DIST_W-1:0]])) begin
               status_in = STATUS_REPLAY;
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = status_ff;
         rsp_data_in.known_sender = known_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         label_ff[0]  <= '0;
         label_ff[1]  <= '0;
         cur_ep_ff    <= '0;
         nxt_ep_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         label_ff     <= label_in;
         cur_ep_ff    <= cur_ep_in;
         nxt_ep_ff    <= nxt_ep_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      iss_cnt_ff    <= iss_cnt_in;
      cmp_slot_ff   <= cmp_slot_in;
      known_ff      <= known_in;
      known_slot_ff <= known_slot_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      floor_ff      <= floor_in;
      slot_abs_ff   <= slot_abs_in;
      bank_ff       <= bank_in;
      gt_ff         <= gt_in;
      diff_ff       <= diff_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `GRWT_ASSERT(a_accept_starts_scan, req_acc |=> state_ff == ST_SCAN, "request accepted but no scan")
   `GRWT_ASSERT(a_scan_drained, state_ff == ST_DECIDE |-> !cmp_vld_ff && !iss_more, "scan not drained")
   `GRWT_ASSERT(a_sndr_write_slot, snd_wr_en |-> known_ff || free_ff, "sender write without a slot")
   `GRWT_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && !rsp_valid_ff, "not idle after reset")

endmodule

// ===== sv/grwt_sub.sv =====
// Shared 64-bit subtract and compare unit.
`timescale 1ns / 1ps

module grwt_sub (
   input  logic [63:0]          a,
   input  logic [63:0]          b,
   output grwt_pkg::sub_res_type res
);
   import grwt_pkg::*;

   logic [64:0] wide;

   assign wide       = {1'b0, a} - {1'b0, b};
   assign res.diff   = wide[63:0];
   assign res.borrow = wide[64];
   assign res.zero   = (wide[63:0] == 64'd0);

endmodule

// ===== sv/grwt_sndr_store.sv =====
// Sender table: ids and boot floors for both scopes, registered read.
`timescale 1ns / 1ps

module grwt_sndr_store #(
   parameter  int SENDERS = grwt_pkg::SENDERS_DEF,
   localparam int ADDR_W  = $clog2(2 * SENDERS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output grwt_pkg::sndr_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  grwt_pkg::sndr_entry_type wr_data
);
   import grwt_pkg::*;

   localparam int DEPTH = 2 * SENDERS;

   sndr_entry_type    mem_ff [DEPTH];
   sndr_entry_type    rd_q_ff;
   logic              rd_vld_ff;
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;

   // an unwritten entry reads as free
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/grwt_win_store.sv =====
// Window store: top and mask per slot and bank, with per-entry valid bits.
`timescale 1ns / 1ps

module grwt_win_store #(
   parameter  int SENDERS = grwt_pkg::SENDERS_DEF,
   localparam int WADDR_W = $clog2(4 * SENDERS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  grwt_pkg::win_ctrl_type  ctrl,
   input  logic [WADDR_W-1:0]      addr,
   input  grwt_pkg::win_entry_type wr_data,
   output grwt_pkg::win_entry_type rd_data
);
   import grwt_pkg::*;

   localparam int DEPTH = 4 * SENDERS;

   win_entry_type     mem_ff [DEPTH];
   win_entry_type     rd_q_ff;
   logic              rd_vld_ff;
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;

   // a cleared or unwritten entry reads as zero
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < DEPTH; k++) begin
         if (ctrl.clr_bank_en && (k % 2 == int'(ctrl.clr_bank))) begin
            vld_in[k] = 1'b0;
         end
         if (ctrl.clr_slot_en && (WADDR_W'(k) >> 1) == (addr >> 1)) begin
            vld_in[k] = 1'b0;
         end
      end
      if (ctrl.wr_en) begin
         vld_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (ctrl.rd_en) begin
            rd_vld_ff <= vld_ff[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_q_ff <= mem_ff[addr];
      end
   end

endmodule
